@@ src/lcd4_pkg.sv @@
// ----------------------------------------------------------------------------
// lcd4_pkg
// Shared types and constants for the 4-bit character LCD controller.
// ----------------------------------------------------------------------------
package lcd4_pkg;

	// Request codes on the slave stream
	localparam logic [2:0] CMD_COMMAND  = 3'd0;
	localparam logic [2:0] CMD_DATA     = 3'd1;
	localparam logic [2:0] CMD_CURSOR   = 3'd2;
	localparam logic [2:0] CMD_POWER_UP = 3'd3;
	localparam logic [2:0] CMD_CLEAR    = 3'd4;

	// Configuration register indexes
	localparam logic [2:0] CFG_POWER_UP_WAIT = 3'd0;
	localparam logic [2:0] CFG_STEP_WAIT     = 3'd1;
	localparam logic [2:0] CFG_PULSE         = 3'd2;
	localparam logic [2:0] CFG_FUNCTION_SET  = 3'd3;
	localparam logic [2:0] CFG_DISPLAY_CTRL  = 3'd4;
	localparam logic [2:0] CFG_ENTRY_MODE    = 3'd5;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// Reset values
	localparam logic [15:0] RST_POWER_UP_WAIT = 16'd2000;
	localparam logic [7:0]  RST_STEP_WAIT     = 8'd1;
	localparam logic [7:0]  RST_FUNCTION_SET  = 8'h2A;
	localparam logic [7:0]  RST_DISPLAY_CTRL  = 8'h0C;
	localparam logic [7:0]  RST_ENTRY_MODE    = 8'h06;

	// HD44780 command bytes
	localparam logic [7:0] LCD_CLEAR_DISPLAY = 8'h01;
	localparam logic [7:0] LCD_SET_DDRAM     = 8'h80;

	// DDRAM row bases for a 20x4 panel
	localparam logic [7:0] ROW_BASE_1 = 8'h40;
	localparam logic [7:0] ROW_BASE_2 = 8'h14;
	localparam logic [7:0] ROW_BASE_3 = 8'h54;

	// Init nibbles
	localparam logic [3:0] NIB_INIT_8BIT = 4'h3;
	localparam logic [3:0] NIB_INIT_4BIT = 4'h2;

	// Pulse counts
	localparam int          PULSE_IDX_W      = 4;
	localparam logic [3:0]  BYTE_LAST_IDX    = 4'd1;
	localparam logic [3:0]  POWER_LAST_IDX   = 4'd13;
	localparam logic [3:0]  POWER_NIB_COUNT  = 4'd4;

	localparam int LCD4_FIFO_DEPTH = 2;

	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 32;

	typedef enum logic {
		REQ_BYTE,
		REQ_POWER_UP
	} req_kind_t;

	// One queued request for the sequencer
	typedef struct packed {
		req_kind_t  kind;
		logic       rs;
		logic [7:0] byte_value;
	} req_t;

	// Live configuration seen by the sequencer
	typedef struct packed {
		logic [15:0] power_up_wait_ms;
		logic [7:0]  step_wait_ms;
		logic [7:0]  function_set_word;
		logic [7:0]  display_control_word;
		logic [7:0]  entry_mode_word;
	} cfg_t;

	// One enable pulse
	typedef struct packed {
		logic        rs_level;
		logic [3:0]  nibble;
		logic [15:0] wait_before_ms;
		logic [7:0]  wait_after_ms;
		logic        last;
	} pulse_t;

endpackage

@@ src/char_lcd_4bit_interface_top.sv @@
// ----------------------------------------------------------------------------
// char_lcd_4bit_interface_top
// HD44780-style character LCD controller, 4-bit bus mode.
// ----------------------------------------------------------------------------
// Each request on the slave stream becomes a run of enable-pulse descriptors
// on the master stream, tlast marking the final pulse of the request. Command,
// data, cursor and clear requests give two pulses (high nibble, then low);
// the power-up request gives 14. The sequencer issues one pulse per cycle
// unless m_tready stalls the output; consecutive requests follow with no gap,
// since the decoder feeds a request queue and the sequencer picks up the next
// request on the last pulse of the current one. Unknown request codes are
// taken and produce nothing. Registers are to be written by the user through
// cfg_we/cfg_index/cfg_data only while the block is idle, which the block
// does not enforce; pulse_ms is applied by the pin driver and is not stored here.
// ----------------------------------------------------------------------------
module char_lcd_4bit_interface_top import lcd4_pkg::*; #(
	parameter int FIFO_DEPTH = LCD4_FIFO_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [2:0] cmd, [10:3] byte_value, [18:11] row, [26:19] col, [31:27] zero
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [0] rs_level, [4:1] nibble, [20:5] wait_before_ms, [28:21] wait_after_ms,
	// [31:29] zero
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tlast,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t   cfg_q;
	logic   dec_valid;
	req_t   dec_req;
	logic   fifo_full;
	logic   fifo_avail;
	req_t   fifo_head;
	logic   fifo_pop;
	logic   fifo_push;
	pulse_t pulse;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.power_up_wait_ms     <= RST_POWER_UP_WAIT;
			cfg_q.step_wait_ms         <= RST_STEP_WAIT;
			cfg_q.function_set_word    <= RST_FUNCTION_SET;
			cfg_q.display_control_word <= RST_DISPLAY_CTRL;
			cfg_q.entry_mode_word      <= RST_ENTRY_MODE;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_POWER_UP_WAIT: cfg_q.power_up_wait_ms     <= cfg_data;
				CFG_STEP_WAIT:     cfg_q.step_wait_ms         <= cfg_data[7:0];
				CFG_FUNCTION_SET:  cfg_q.function_set_word    <= cfg_data[7:0];
				CFG_DISPLAY_CTRL:  cfg_q.display_control_word <= cfg_data[7:0];
				CFG_ENTRY_MODE:    cfg_q.entry_mode_word      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	lcd4_front u_front (
		.cmd        (s_tdata[2:0]),
		.byte_value (s_tdata[10:3]),
		.row        (s_tdata[18:11]),
		.col        (s_tdata[26:19]),
		.req_valid  (dec_valid),
		.req        (dec_req)
	);

	assign s_tready  = !fifo_full;
	assign fifo_push = s_tvalid && s_tready && dec_valid;

	lcd4_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fifo_push),
		.push_data (dec_req),
		.full      (fifo_full),
		.pop       (fifo_pop),
		.not_empty (fifo_avail),
		.pop_data  (fifo_head)
	);

	lcd4_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.req_avail   (fifo_avail),
		.req_head    (fifo_head),
		.req_pop     (fifo_pop),
		.pulse_valid (m_tvalid),
		.pulse_ready (m_tready),
		.pulse       (pulse)
	);

	assign m_tdata = {3'd0, pulse.wait_after_ms, pulse.wait_before_ms,
	                  pulse.nibble, pulse.rs_level};
	assign m_tlast = pulse.last;

endmodule

@@ src/lcd4_front.sv @@
// ----------------------------------------------------------------------------
// lcd4_front
// Decodes incoming requests into byte or power-up jobs for the queue.
// ----------------------------------------------------------------------------
module lcd4_front import lcd4_pkg::*; (
	input  logic [2:0] cmd,
	input  logic [7:0] byte_value,
	input  logic [7:0] row,
	input  logic [7:0] col,
	output logic       req_valid,
	output req_t       req
);

	logic [7:0] row_base;

	always_comb begin
		case (row)
			8'd1:    row_base = ROW_BASE_1;
			8'd2:    row_base = ROW_BASE_2;
			8'd3:    row_base = ROW_BASE_3;
			default: row_base = 8'h00;
		endcase
	end

	always_comb begin
		req_valid      = 1'b1;
		req.kind       = REQ_BYTE;
		req.rs         = 1'b0;
		req.byte_value = byte_value;
		case (cmd)
			CMD_COMMAND: begin
				req.rs = 1'b0;
			end
			CMD_DATA: begin
				req.rs = 1'b1;
			end
			CMD_CURSOR: begin
				// 8-bit add wraps mod 256
				req.byte_value = (row_base + col) | LCD_SET_DDRAM;
			end
			CMD_POWER_UP: begin
				req.kind = REQ_POWER_UP;
			end
			CMD_CLEAR: begin
				req.byte_value = LCD_CLEAR_DISPLAY;
			end
			default: begin
				// unknown codes are consumed with no output
				req_valid = 1'b0;
			end
		endcase
	end

endmodule

@@ src/lcd4_fifo.sv @@
// ----------------------------------------------------------------------------
// lcd4_fifo
// Small request queue between the decoder and the pulse sequencer.
// ----------------------------------------------------------------------------
module lcd4_fifo import lcd4_pkg::*; #(
	parameter int DEPTH = LCD4_FIFO_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  req_t push_data,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output req_t pop_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	req_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_FULL);
	assign not_empty = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ src/lcd4_seq.sv @@
// ----------------------------------------------------------------------------
// lcd4_seq
// Pulse sequencer: walks each queued request one enable pulse per cycle while pulse_ready does not stall it.
// ----------------------------------------------------------------------------
module lcd4_seq import lcd4_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   req_avail,
	input  req_t   req_head,
	output logic   req_pop,
	output logic   pulse_valid,
	input  logic   pulse_ready,
	output pulse_t pulse
);

	logic                   cur_valid_q;
	req_t                   cur_q;
	logic [PULSE_IDX_W-1:0] idx_q;
	logic                   rs_held_q;
	logic                   out_valid_q;
	pulse_t                 out_q;

	logic                   load;
	logic                   advance;
	logic                   cur_last;
	logic [PULSE_IDX_W-1:0] pw_idx;
	logic [7:0]             sel_byte;
	logic                   sel_rs;
	logic                   is_nibble;
	pulse_t                 next_pulse;

	assign load     = !out_valid_q || pulse_ready;
	assign advance  = cur_valid_q && load;
	assign cur_last = (cur_q.kind == REQ_BYTE) ? (idx_q == BYTE_LAST_IDX)
	                                           : (idx_q == POWER_LAST_IDX);
	assign req_pop  = req_avail && (!cur_valid_q || (advance && cur_last));

	// Byte select for the power-up command phase
	assign pw_idx = idx_q - POWER_NIB_COUNT;

	always_comb begin
		is_nibble = 1'b0;
		sel_rs    = cur_q.rs;
		sel_byte  = cur_q.byte_value;
		if (cur_q.kind == REQ_POWER_UP) begin
			sel_rs    = 1'b0;
			is_nibble = (idx_q < POWER_NIB_COUNT);
			case (pw_idx[PULSE_IDX_W-1:1])
				3'd0:    sel_byte = cfg.function_set_word;
				3'd1:    sel_byte = cfg.display_control_word;
				3'd2:    sel_byte = LCD_CLEAR_DISPLAY;
				3'd3:    sel_byte = cfg.entry_mode_word;
				default: sel_byte = LCD_CLEAR_DISPLAY;
			endcase
		end
	end

	always_comb begin
		next_pulse.last = cur_last;
		if (is_nibble) begin
			next_pulse.rs_level       = rs_held_q;
			next_pulse.nibble         = (idx_q == 4'd3) ? NIB_INIT_4BIT : NIB_INIT_8BIT;
			next_pulse.wait_before_ms = (idx_q == '0) ? cfg.power_up_wait_ms : 16'd0;
			next_pulse.wait_after_ms  = cfg.step_wait_ms;
		end else if (!idx_q[0]) begin
			// high nibble: settle for twice the step wait before the pulse, after RS changes
			next_pulse.rs_level       = sel_rs;
			next_pulse.nibble         = sel_byte[7:4];
			next_pulse.wait_before_ms = {7'd0, cfg.step_wait_ms, 1'b0};
			next_pulse.wait_after_ms  = 8'd0;
		end else begin
			next_pulse.rs_level       = sel_rs;
			next_pulse.nibble         = sel_byte[3:0];
			next_pulse.wait_before_ms = 16'd0;
			next_pulse.wait_after_ms  = cfg.step_wait_ms;
		end
	end

	always_ff @(posedge clk) begin
		if (req_pop) begin
			cur_q <= req_head;
		end
		if (advance) begin
			out_q <= next_pulse;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			rs_held_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req_pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (advance && cur_last) begin
				cur_valid_q <= 1'b0;
			end else if (advance) begin
				idx_q <= idx_q + 1'b1;
			end
			if (advance && !is_nibble) begin
				rs_held_q <= sel_rs;
			end
			if (load) begin
				out_valid_q <= cur_valid_q;
			end
		end
	end

	assign pulse_valid = out_valid_q;
	assign pulse       = out_q;

endmodule
